>>> rtl/mzia_pkg.sv
// Shared types, constants and helpers for the multizone alarm controller.
// No dependencies; every other rtl file imports this package.
package mzia_pkg;

  localparam int CFG_W     = 7;
  localparam int NUM_REGS  = 5;
  localparam int ADDR_W    = 5;
  localparam int PDATA_W   = 32;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  // Event codes
  localparam logic [2:0] OP_SECOND  = 3'd0;
  localparam logic [2:0] OP_REFRESH = 3'd1;
  localparam logic [2:0] OP_ARM     = 3'd2;
  localparam logic [2:0] OP_PRESS   = 3'd3;
  localparam logic [2:0] OP_RELEASE = 3'd4;

  // Register indexes
  localparam logic [2:0] REG_EXIT_LOAD   = 3'd0;
  localparam logic [2:0] REG_ENTRY_LOAD  = 3'd1;
  localparam logic [2:0] REG_SIREN_DIR   = 3'd2;
  localparam logic [2:0] REG_SIREN_ENTRY = 3'd3;
  localparam logic [2:0] REG_SHOW_SECS   = 3'd4;

  localparam logic [CFG_W-1:0] EXIT_LOAD_RST   = 7'd16;
  localparam logic [CFG_W-1:0] ENTRY_LOAD_RST  = 7'd16;
  localparam logic [CFG_W-1:0] SIREN_DIR_RST   = 7'd11;
  localparam logic [CFG_W-1:0] SIREN_ENTRY_RST = 7'd10;
  localparam logic [CFG_W-1:0] SHOW_SECS_RST   = 7'd4;

  // Digit select codes
  localparam logic [1:0] DIG_NONE   = 2'd0;
  localparam logic [1:0] DIG_UNITS  = 2'd1;
  localparam logic [1:0] DIG_TENS   = 2'd2;
  localparam logic [1:0] DIG_STATUS = 2'd3;

  // Mode codes as seen on the result bus
  localparam logic [2:0] MODE_CODE_OFF   = 3'd0;
  localparam logic [2:0] MODE_CODE_ARMED = 3'd1;
  localparam logic [2:0] MODE_CODE_SOUND = 3'd2;
  localparam logic [2:0] MODE_CODE_ENTRY = 3'd3;
  localparam logic [2:0] MODE_CODE_EXIT  = 3'd4;
  localparam logic [2:0] MODE_CODE_SHOW  = 3'd5;

  typedef enum logic [5:0] {
    MODE_OFF   = 6'b000001,
    MODE_ARMED = 6'b000010,
    MODE_SOUND = 6'b000100,
    MODE_ENTRY = 6'b001000,
    MODE_EXIT  = 6'b010000,
    MODE_SHOW  = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [CFG_W-1:0] exit_load;
    logic [CFG_W-1:0] entry_load;
    logic [CFG_W-1:0] siren_direct;
    logic [CFG_W-1:0] siren_after_entry;
    logic [CFG_W-1:0] show_secs;
  } cfg_t;

  typedef struct packed {
    logic             siren_on;
    logic [1:0]       digit_enable;
    logic [3:0]       bcd_value;
    logic [2:0]       mode;
    logic [CFG_W-1:0] seconds_left;
    logic [1:0]       tripped_zone;
  } result_t;

  function automatic logic [2:0] mode_code(mode_t m);
    logic [2:0] c;
    case (m)
      MODE_OFF:   c = MODE_CODE_OFF;
      MODE_ARMED: c = MODE_CODE_ARMED;
      MODE_SOUND: c = MODE_CODE_SOUND;
      MODE_ENTRY: c = MODE_CODE_ENTRY;
      MODE_EXIT:  c = MODE_CODE_EXIT;
      MODE_SHOW:  c = MODE_CODE_SHOW;
      default:    c = MODE_CODE_OFF;
    endcase
    return c;
  endfunction

  // Split a 7-bit count into {tens, units}; x*205>>11 is exact below 1029.
  function automatic logic [7:0] bcd_split(logic [CFG_W-1:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  rem;
    prod = {8'b0, v} * 15'd205;
    tens = prod[14:11];
    rem  = v - ({3'b0, tens} * 7'd10);
    return {tens, rem[3:0]};
  endfunction

endpackage

>>> rtl/multizone_intrusion_alarm_controller.sv
// Channel   Dir  Payload (low bits first)
// s_axis    in   tdata: opcode[2:0], zone[4:3], zero pad to 8 bits
// m_axis    out  tdata: siren_on, digit_enable, bcd_value, mode, seconds_left,
//                tripped_zone, zero pad to 24 bits
// apb       in   five 7-bit load registers at byte addresses 0,4,8,12,16
//
// One event per clock while s_tready is high: the state update and the result
// are computed combinationally, and the result lands in a two-entry output buffer.
// Synchronous active-high rst restores the default loads and clears all control state.
// s_tready drops only when both output buffer entries are full.
module multizone_intrusion_alarm_controller import mzia_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // opcode[2:0], zone[4:3]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // siren_on[0], digit_enable[2:1],
                                           // bcd_value[6:3], mode[9:7],
                                           // seconds_left[16:10], tripped_zone[18:17]
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready
);

  cfg_t    cfg;
  result_t result_next;
  result_t out_data;
  logic    accept;

  assign accept = s_tvalid && s_tready;

  mzia_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mzia_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .opcode      (s_tdata[2:0]),
    .zone        (s_tdata[4:3]),
    .cfg         (cfg),
    .result_next (result_next)
  );

  mzia_out_buf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result_next),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data)
  );

  assign m_tdata = {5'b0, out_data.tripped_zone, out_data.seconds_left, out_data.mode,
                    out_data.bcd_value, out_data.digit_enable, out_data.siren_on};

endmodule

>>> rtl/mzia_cfg_regs.sv
// Configuration register file with an APB-style write/read port.
// Depends on mzia_pkg.
module mzia_cfg_regs import mzia_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;
  logic [CFG_W-1:0] rd_val;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.exit_load         <= EXIT_LOAD_RST;
      cfg.entry_load        <= ENTRY_LOAD_RST;
      cfg.siren_direct      <= SIREN_DIR_RST;
      cfg.siren_after_entry <= SIREN_ENTRY_RST;
      cfg.show_secs         <= SHOW_SECS_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_EXIT_LOAD:   cfg.exit_load         <= pwdata[CFG_W-1:0];
        REG_ENTRY_LOAD:  cfg.entry_load        <= pwdata[CFG_W-1:0];
        REG_SIREN_DIR:   cfg.siren_direct      <= pwdata[CFG_W-1:0];
        REG_SIREN_ENTRY: cfg.siren_after_entry <= pwdata[CFG_W-1:0];
        REG_SHOW_SECS:   cfg.show_secs         <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_EXIT_LOAD:   rd_val = cfg.exit_load;
      REG_ENTRY_LOAD:  rd_val = cfg.entry_load;
      REG_SIREN_DIR:   rd_val = cfg.siren_direct;
      REG_SIREN_ENTRY: rd_val = cfg.siren_after_entry;
      REG_SHOW_SECS:   rd_val = cfg.show_secs;
      default:         rd_val = '0;
    endcase
  end

  assign prdata = {{(PDATA_W-CFG_W){1'b0}}, rd_val};

endmodule

>>> rtl/mzia_core.sv
// Alarm state registers and the single-pass next-state logic for one event.
// Depends on mzia_pkg.
module mzia_core import mzia_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [2:0] opcode,
  input  logic [1:0] zone,
  input  cfg_t       cfg,
  output result_t    result_next
);

  mode_t            mode, mode_next;
  logic [CFG_W-1:0] countdown, countdown_next;
  logic [1:0]       zone_reg, zone_reg_next;
  logic [3:0]       units_digit, units_digit_next;
  logic [3:0]       tens_digit, tens_digit_next;
  logic [3:0]       status_digit, status_digit_next;
  logic [1:0]       scan_position, scan_position_next;
  logic             siren, siren_next;
  logic [1:0]       enable, enable_next;
  logic [3:0]       bcd, bcd_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_OFF;
      countdown     <= '0;
      zone_reg      <= '0;
      units_digit   <= '0;
      tens_digit    <= '0;
      status_digit  <= '0;
      scan_position <= '0;
      siren         <= 1'b0;
      enable        <= DIG_NONE;
      bcd           <= '0;
    end else if (accept) begin
      mode          <= mode_next;
      countdown     <= countdown_next;
      zone_reg      <= zone_reg_next;
      units_digit   <= units_digit_next;
      tens_digit    <= tens_digit_next;
      status_digit  <= status_digit_next;
      scan_position <= scan_position_next;
      siren         <= siren_next;
      enable        <= enable_next;
      bcd           <= bcd_next;
    end
  end

  always_comb begin
    logic             timed;
    logic             timed_m;
    logic             shows_tens;
    logic [CFG_W-1:0] cd_dec;
    logic [7:0]       split;
    mode_t            m_new;
    logic [CFG_W-1:0] cd_new;

    mode_next          = mode;
    countdown_next     = countdown;
    zone_reg_next      = zone_reg;
    units_digit_next   = units_digit;
    tens_digit_next    = tens_digit;
    status_digit_next  = status_digit;
    scan_position_next = scan_position;
    siren_next         = siren;
    enable_next        = enable;
    bcd_next           = bcd;

    timed      = (mode == MODE_SOUND) || (mode == MODE_ENTRY) ||
                 (mode == MODE_EXIT) || (mode == MODE_SHOW);
    shows_tens = (mode == MODE_SOUND) || (mode == MODE_ENTRY) || (mode == MODE_EXIT);
    cd_dec     = countdown - 7'd1;
    m_new      = mode;
    cd_new     = cd_dec;

    // Countdown expiry: entry -> sounding, sounding -> zone display, else armed.
    if (cd_dec == '0) begin
      case (mode)
        MODE_ENTRY: begin
          m_new  = MODE_SOUND;
          cd_new = cfg.siren_after_entry;
        end
        MODE_SOUND: begin
          m_new  = MODE_SHOW;
          cd_new = cfg.show_secs;
        end
        default: m_new = MODE_ARMED;
      endcase
    end
    timed_m = (m_new == MODE_SOUND) || (m_new == MODE_ENTRY) || (m_new == MODE_EXIT);
    split   = bcd_split(cd_new);

    case (opcode)
      OP_SECOND: begin
        if (timed) begin
          mode_next      = m_new;
          countdown_next = cd_new;
          if (cd_dec == '0 && mode == MODE_ENTRY) begin
            zone_reg_next = 2'd1;
          end
          if (cd_dec == '0 && mode == MODE_SOUND) begin
            units_digit_next = {2'b00, zone_reg};
          end
          if (m_new == MODE_SOUND) begin
            siren_next = 1'b1;
          end
          if (timed_m) begin
            tens_digit_next  = split[7:4];
            units_digit_next = split[3:0];
          end
        end else if (mode == MODE_ARMED) begin
          siren_next = 1'b0;
        end
      end
      OP_REFRESH: begin
        // Fall through the scan slots until one has something to show.
        enable_next = DIG_NONE;
        if (scan_position == 2'd0 && timed) begin
          bcd_next    = units_digit;
          enable_next = DIG_UNITS;
        end else if (scan_position <= 2'd1 && shows_tens) begin
          bcd_next    = tens_digit;
          enable_next = DIG_TENS;
        end else if (scan_position <= 2'd2 && mode == MODE_OFF) begin
          bcd_next    = status_digit;
          enable_next = DIG_STATUS;
        end
        scan_position_next = (scan_position >= 2'd2) ? 2'd0 : scan_position + 2'd1;
      end
      OP_ARM: begin
        if (mode == MODE_OFF) begin
          mode_next      = MODE_EXIT;
          countdown_next = cfg.exit_load;
        end else if (mode != MODE_SHOW) begin
          mode_next        = MODE_OFF;
          siren_next       = 1'b0;
          units_digit_next = '0;
          tens_digit_next  = '0;
        end
      end
      OP_PRESS: begin
        // Ignore presses while a zone is held in the status digit.
        if (zone != 2'd0 && status_digit == '0) begin
          if (mode == MODE_OFF) begin
            status_digit_next = {2'b00, zone};
          end else if (zone == 2'd1) begin
            if (mode == MODE_ARMED) begin
              countdown_next = cfg.entry_load;
              mode_next      = MODE_ENTRY;
            end
          end else if (mode == MODE_ARMED || mode == MODE_ENTRY || mode == MODE_EXIT) begin
            countdown_next = cfg.siren_direct;
            mode_next      = MODE_SOUND;
            zone_reg_next  = zone;
          end
        end
      end
      OP_RELEASE: begin
        if (zone != 2'd0 && status_digit == {2'b00, zone}) begin
          status_digit_next = '0;
        end
      end
      default: ;
    endcase
  end

  assign result_next.siren_on     = siren_next;
  assign result_next.digit_enable = enable_next;
  assign result_next.bcd_value    = bcd_next;
  assign result_next.mode         = mode_code(mode_next);
  assign result_next.seconds_left = countdown_next;
  assign result_next.tripped_zone = zone_reg_next;

endmodule

>>> rtl/mzia_out_buf.sv
// Two-entry result buffer: output register plus skid stage.
// Depends on mzia_pkg.
module mzia_out_buf import mzia_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    a_valid, b_valid;
  result_t a_data, b_data;
  logic    pop;

  assign pop       = a_valid && out_ready;
  assign in_ready  = !b_valid;
  assign out_valid = a_valid;
  assign out_data  = a_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (b_valid) begin
      // Drain the skid stage into the output register.
      if (pop) begin
        b_valid <= 1'b0;
      end
    end else if (push) begin
      if (!a_valid || pop) begin
        a_valid <= 1'b1;
      end else begin
        b_valid <= 1'b1;
      end
    end else if (pop) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid) begin
      if (pop) begin
        a_data <= b_data;
      end
    end else if (push) begin
      if (!a_valid || pop) begin
        a_data <= push_data;
      end else begin
        b_data <= push_data;
      end
    end
  end

endmodule

>>> rtl/mzia_checker.sv
// Port-level checks for the alarm controller, bound to the top level.
// Depends on mzia_pkg.
module mzia_checker import mzia_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // No result may be offered right after a reset cycle.
  a_idle_after_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // After every accepted item, a result is offered in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted item produced no result");

  // Backpressure only while a result is waiting.
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no pending result");

  // Siren never drives while disarmed or in exit delay.
  a_siren_mode: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[9:7] != MODE_CODE_OFF && m_tdata[9:7] != MODE_CODE_EXIT)
    else $error("siren on while disarmed or in exit delay");

endmodule

bind multizone_intrusion_alarm_controller mzia_checker u_mzia_checker (.*);

>>> bench/alarm_monitor.sv
// Watches the event, readout and register channels of the alarm controller, models
// its modes, countdown and display scan, and compares each readout with the model.
// Depends on mzia_pkg for widths, event codes, mode codes and register indexes.
module alarm_monitor import mzia_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // opcode[2:0], zone[4:3]
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,   // siren_on[0], digit_enable[2:1],
                                           // bcd_value[6:3], mode[9:7],
                                           // seconds_left[16:10], tripped_zone[18:17]
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  input  logic [PDATA_W-1:0]    prdata,
  input  logic                  pready,
  output int                    failures,
  output int                    pending,
  output logic [2:0]            alarm_mode
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [CFG_W-1:0] loads [NUM_REGS];

  logic [2:0]       mode_q;
  logic [CFG_W-1:0] count_q;
  logic [1:0]       zone_q;
  logic [3:0]       units_q;
  logic [3:0]       tens_q;
  logic [3:0]       status_q;
  logic [1:0]       scan_q;
  logic             siren_q;
  logic [1:0]       enable_q;
  logic [3:0]       bcd_q;

  result_t predicted_readouts [$];
  int      readout_count;

  task automatic report(input string msg);
    failures++;
    if (failures <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [6:0] got, input logic [6:0] want);
    if (got !== want)
      report($sformatf("readout %0d %s: expected %0d, got %0d", readout_count, name, want, got));
  endtask

  task automatic step_alarm(input logic [2:0] op, input logic [1:0] z);
    logic [2:0]       m;
    logic [1:0]       p;
    logic             lit;
    logic [CFG_W-1:0] q;
    logic [CFG_W-1:0] r;
    m = mode_q;
    case (op)
      OP_SECOND: begin
        if (m >= MODE_CODE_SOUND && m <= MODE_CODE_SHOW) begin
          count_q = count_q - 7'd1;
          if (count_q == 7'd0) begin
            if (m == MODE_CODE_ENTRY) begin
              mode_q  = MODE_CODE_SOUND;
              count_q = loads[REG_SIREN_ENTRY];
              zone_q  = 2'd1;
            end else if (m == MODE_CODE_SOUND) begin
              mode_q  = MODE_CODE_SHOW;
              count_q = loads[REG_SHOW_SECS];
              units_q = {2'b00, zone_q};
            end else begin
              mode_q = MODE_CODE_ARMED;
            end
          end
          if (mode_q == MODE_CODE_SOUND) siren_q = 1'b1;
          if (mode_q >= MODE_CODE_SOUND && mode_q <= MODE_CODE_EXIT) begin
            q = count_q / 7'd10;
            r = count_q % 7'd10;
            tens_q  = q[3:0];
            units_q = r[3:0];
          end
        end else if (m == MODE_CODE_ARMED) begin
          siren_q = 1'b0;
        end
      end
      OP_REFRESH: begin
        // scan falls through to the next position when the current one is dark
        p = scan_q;
        lit = 1'b0;
        enable_q = DIG_NONE;
        if (p == 2'd0) begin
          if (m >= MODE_CODE_SOUND && m <= MODE_CODE_SHOW) begin
            bcd_q = units_q;
            enable_q = DIG_UNITS;
            lit = 1'b1;
          end else begin
            p = 2'd1;
          end
        end
        if (!lit && p == 2'd1) begin
          if (m >= MODE_CODE_SOUND && m <= MODE_CODE_EXIT) begin
            bcd_q = tens_q;
            enable_q = DIG_TENS;
            lit = 1'b1;
          end else begin
            p = 2'd2;
          end
        end
        if (!lit && p == 2'd2 && m == MODE_CODE_OFF) begin
          bcd_q = status_q;
          enable_q = DIG_STATUS;
        end
        scan_q = (scan_q >= 2'd2) ? 2'd0 : scan_q + 2'd1;
      end
      OP_ARM: begin
        if (m == MODE_CODE_OFF) begin
          mode_q  = MODE_CODE_EXIT;
          count_q = loads[REG_EXIT_LOAD];
        end else if (m >= MODE_CODE_ARMED && m <= MODE_CODE_EXIT) begin
          mode_q  = MODE_CODE_OFF;
          siren_q = 1'b0;
          units_q = 4'd0;
          tens_q  = 4'd0;
        end
      end
      OP_PRESS: begin
        // a held zone blocks every press until it is released
        if (z != 2'd0 && status_q == 4'd0) begin
          if (m == MODE_CODE_OFF) begin
            status_q = {2'b00, z};
          end else if (z == 2'd1) begin
            if (m == MODE_CODE_ARMED) begin
              count_q = loads[REG_ENTRY_LOAD];
              mode_q  = MODE_CODE_ENTRY;
            end
          end else if (m == MODE_CODE_ARMED || m == MODE_CODE_ENTRY || m == MODE_CODE_EXIT) begin
            count_q = loads[REG_SIREN_DIR];
            mode_q  = MODE_CODE_SOUND;
            zone_q  = z;
          end
        end
      end
      OP_RELEASE: begin
        if (z != 2'd0 && status_q == {2'b00, z}) status_q = 4'd0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    logic [2:0] idx;
    if (rst) begin
      loads[REG_EXIT_LOAD]   = EXIT_LOAD_RST;
      loads[REG_ENTRY_LOAD]  = ENTRY_LOAD_RST;
      loads[REG_SIREN_DIR]   = SIREN_DIR_RST;
      loads[REG_SIREN_ENTRY] = SIREN_ENTRY_RST;
      loads[REG_SHOW_SECS]   = SHOW_SECS_RST;
      mode_q   = MODE_CODE_OFF;
      count_q  = '0;
      zone_q   = '0;
      units_q  = '0;
      tens_q   = '0;
      status_q = '0;
      scan_q   = '0;
      siren_q  = 1'b0;
      enable_q = DIG_NONE;
      bcd_q    = '0;
      predicted_readouts.delete();
      readout_count = 0;
      failures = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (predicted_readouts.size() == 0) begin
          report($sformatf("readout %0d arrived with none pending: %h", readout_count, m_tdata));
        end else begin
          want = predicted_readouts.pop_front();
          got.siren_on     = m_tdata[0];
          got.digit_enable = m_tdata[2:1];
          got.bcd_value    = m_tdata[6:3];
          got.mode         = m_tdata[9:7];
          got.seconds_left = m_tdata[16:10];
          got.tripped_zone = m_tdata[18:17];
          check_field("siren_on", 7'(got.siren_on), 7'(want.siren_on));
          check_field("digit_enable", 7'(got.digit_enable), 7'(want.digit_enable));
          check_field("bcd_value", 7'(got.bcd_value), 7'(want.bcd_value));
          check_field("mode", 7'(got.mode), 7'(want.mode));
          check_field("seconds_left", got.seconds_left, want.seconds_left);
          check_field("tripped_zone", 7'(got.tripped_zone), 7'(want.tripped_zone));
        end
        readout_count++;
      end
      if (psel && penable && pready) begin
        idx = paddr[ADDR_W-1:2];
        if (pwrite) begin
          if (idx < NUM_REGS) loads[idx] = pwdata[CFG_W-1:0];
        end else if (idx < NUM_REGS && prdata !== {{(PDATA_W-CFG_W){1'b0}}, loads[idx]}) begin
          report($sformatf("register %0d read: expected %0d, got %0d", idx, loads[idx], prdata));
        end
      end
      if (s_tvalid && s_tready) begin
        step_alarm(s_tdata[2:0], s_tdata[4:3]);
        want.siren_on     = siren_q;
        want.digit_enable = enable_q;
        want.bcd_value    = bcd_q;
        want.mode         = mode_q;
        want.seconds_left = count_q;
        want.tripped_zone = zone_q;
        predicted_readouts.push_back(want);
      end
    end
    pending = predicted_readouts.size();
    alarm_mode = mode_q;
  end

endmodule

>>> bench/testbench.sv
// Top of the alarm controller bench: clock, reset, event stimulus, register writes,
// readout back-pressure and the verdict. Depends on mzia_pkg and alarm_monitor.
module testbench;
  import mzia_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [PDATA_W-1:0]    pwdata = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  int         failures;
  int         results_pending;
  logic [2:0] alarm_mode;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;
  int counted_items = 0;

  always #10 clk = ~clk;

  multizone_intrusion_alarm_controller dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  alarm_monitor monitor (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .failures(failures), .pending(results_pending), .alarm_mode(alarm_mode)
  );

  // readout side: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_requests != holds_done) begin
      holds_done++;
      hold_left = 80;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL multizone_intrusion_alarm_controller");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_item(input logic [2:0] op, input logic [1:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, z, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if (op <= OP_RELEASE && !(op >= OP_PRESS && z == 2'd0)) counted_items++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (results_pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // write one load register, then read it back
  task automatic program_load(input logic [2:0] idx, input logic [CFG_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {{(PDATA_W-CFG_W){1'b0}}, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] exit_l, input logic [CFG_W-1:0] entry_l,
                           input logic [CFG_W-1:0] siren_l, input logic [CFG_W-1:0] after_l,
                           input logic [CFG_W-1:0] show_l);
    drain();
    program_load(REG_EXIT_LOAD, exit_l);
    program_load(REG_ENTRY_LOAD, entry_l);
    program_load(REG_SIREN_DIR, siren_l);
    program_load(REG_SIREN_ENTRY, after_l);
    program_load(REG_SHOW_SECS, show_l);
  endtask

  task automatic tick_or_refresh();
    if ($urandom_range(9) < 7) send_item(OP_SECOND, 2'($urandom_range(3)));
    else send_item(OP_REFRESH, 2'($urandom_range(3)));
  endtask

  task automatic run_until_leaves(input logic [2:0] m);
    int n;
    n = 0;
    while (alarm_mode == m && n < 300) begin
      tick_or_refresh();
      n++;
    end
  endtask

  task automatic go_off();
    int n;
    n = 0;
    while (alarm_mode != MODE_CODE_OFF && n < 10) begin
      if (alarm_mode == MODE_CODE_SHOW) run_until_leaves(MODE_CODE_SHOW);
      else send_item(OP_ARM, 2'($urandom_range(3)));
      n++;
    end
  endtask

  // one arm / trip / alarm / re-arm / disarm sequence with random branching
  task automatic alarm_cycle();
    logic [1:0] z;
    int pick;
    go_off();
    if ($urandom_range(4) == 0) begin
      z = 2'($urandom_range(1, 3));
      send_item(OP_PRESS, z);
      send_item(OP_PRESS, (z == 2'd3) ? 2'd1 : z + 2'd1);
      repeat (3) send_item(OP_REFRESH, 2'($urandom_range(3)));
      if ($urandom_range(1) == 0) begin
        send_item(OP_ARM, 2'd0);
        send_item(OP_ARM, 2'd0);
      end
      send_item(OP_RELEASE, (z == 2'd1) ? 2'd3 : z - 2'd1);
      send_item(OP_RELEASE, z);
    end
    send_item(OP_ARM, 2'($urandom_range(3)));
    pick = $urandom_range(9);
    if (pick == 0) begin
      repeat ($urandom_range(0, 2)) tick_or_refresh();
      send_item(OP_ARM, 2'd0);
      return;
    end
    if (pick == 1) begin
      send_item(OP_PRESS, 2'($urandom_range(2, 3)));
    end else begin
      run_until_leaves(MODE_CODE_EXIT);
      repeat ($urandom_range(0, 3)) tick_or_refresh();
      pick = $urandom_range(9);
      if (pick < 4) begin
        send_item(OP_PRESS, 2'd1);
        send_item(OP_RELEASE, 2'd1);
        pick = $urandom_range(7);
        if (pick == 0) begin
          send_item(OP_PRESS, 2'($urandom_range(2, 3)));
        end else if (pick == 1) begin
          send_item(OP_ARM, 2'd0);
          return;
        end else begin
          run_until_leaves(MODE_CODE_ENTRY);
        end
      end else if (pick < 8) begin
        z = 2'($urandom_range(2, 3));
        send_item(OP_PRESS, z);
        send_item(OP_RELEASE, z);
      end else begin
        send_item(OP_ARM, 2'd0);
        return;
      end
    end
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 3)) tick_or_refresh();
      send_item(OP_ARM, 2'd0);
      return;
    end
    run_until_leaves(MODE_CODE_SOUND);
    // the button is ignored while the tripped zone is on show
    if ($urandom_range(2) == 0) send_item(OP_ARM, 2'd0);
    run_until_leaves(MODE_CODE_SHOW);
    repeat ($urandom_range(1, 4)) tick_or_refresh();
    send_item(OP_ARM, 2'd0);
  endtask

  task automatic noise_burst();
    logic [2:0] op;
    logic       pressed;
    pressed = 1'b0;
    repeat ($urandom_range(0, 4)) begin
      op = 3'($urandom_range(7));
      if (op == OP_PRESS) pressed = 1'b1;
      send_item(op, 2'($urandom_range(3)));
    end
    if (pressed) begin
      send_item(OP_RELEASE, 2'd1);
      send_item(OP_RELEASE, 2'd2);
      send_item(OP_RELEASE, 2'd3);
    end
  endtask

  task automatic random_phase(input int budget, input bit with_pressure);
    int target;
    int saved;
    target = counted_items + budget;
    while (counted_items < target) begin
      alarm_cycle();
      noise_burst();
      if (with_pressure) begin
        // hold the readout side off while events keep coming back to back
        with_pressure = 1'b0;
        saved = send_idle_pct;
        send_idle_pct = 0;
        hold_requests++;
        repeat (30) tick_or_refresh();
        send_idle_pct = saved;
        drain();
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    configure(7'd2, 7'd2, 7'd2, 7'd2, 7'd2);
    // scan with nothing held, then a held zone shown on the status digit
    repeat (3) send_item(OP_REFRESH, 2'd0);
    send_item(OP_PRESS, 2'd2);
    send_item(OP_PRESS, 2'd3);
    send_item(OP_REFRESH, 2'd0);
    send_item(OP_RELEASE, 2'd3);
    send_item(OP_RELEASE, 2'd2);
    send_item(OP_PRESS, 2'd0);
    send_item(3'd5, 2'd3);
    send_item(3'd6, 2'd1);
    send_item(3'd7, 2'd0);
    // arm, entry, siren, zone display, back to armed, disarm
    send_item(OP_ARM, 2'd0);
    send_item(OP_SECOND, 2'd0);
    send_item(OP_SECOND, 2'd0);
    send_item(OP_PRESS, 2'd1);
    send_item(OP_RELEASE, 2'd1);
    repeat (4) send_item(OP_SECOND, 2'd0);
    send_item(OP_REFRESH, 2'd0);
    send_item(OP_ARM, 2'd0);
    repeat (3) send_item(OP_SECOND, 2'd0);
    send_item(OP_ARM, 2'd0);

    send_idle_pct = 28;
    recv_idle_pct = 65;
    configure(7'($urandom_range(1, 8)), 7'($urandom_range(1, 8)), 7'($urandom_range(1, 8)),
              7'($urandom_range(1, 8)), 7'($urandom_range(1, 8)));
    random_phase(100, 1'b1);

    send_idle_pct = 65;
    recv_idle_pct = 28;
    configure(7'd127, 7'd0, 7'd99, 7'd1, 7'd0);
    random_phase(200, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(7'($urandom_range(1, 10)), 7'($urandom_range(1, 10)), 7'($urandom_range(1, 10)),
              7'($urandom_range(1, 10)), 7'($urandom_range(1, 10)));
    random_phase(100, 1'b0);

    drain();
    repeat (10) @(negedge clk);
    if (failures == 0 && results_pending == 0) begin
      $display("PASS multizone_intrusion_alarm_controller");
    end else begin
      $display("FAIL multizone_intrusion_alarm_controller");
    end
    $finish;
  end

endmodule
